>>> hdl/ukt_pkg.sv
// Shared constants, types and a helper function for the unique key table.
package ukt_pkg;

	localparam int CAPACITY     = 1024;
	localparam int PAYLOAD_BITS = 64;
	localparam int ADDR_W       = $clog2(CAPACITY);
	localparam int OCC_W        = 11;
	localparam int KEY_W        = 30;
	localparam int FUNC_W       = 2;
	localparam int STATUS_W     = 3;
	localparam int PAY_PORT_W   = 64;
	localparam int CNT_W        = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT   = 2'd0,
		FN_DELETE   = 2'd1,
		FN_RETRIEVE = 2'd2
	} ukt_func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FOUND     = 3'd4,
		ST_FULL      = 3'd5
	} ukt_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} ukt_state_t;

	// Saturating increment of a result counter.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

>>> hdl/ukt_if.sv
// Request and response channel interfaces of the unique key table.
interface ukt_req_if import ukt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [KEY_W-1:0]    key;
	logic [PAY_PORT_W-1:0] payload;

	modport source (output valid, output func, output key, output payload, input ready);
	modport sink   (input valid, input func, input key, input payload, output ready);
endinterface

interface ukt_rsp_if import ukt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [PAY_PORT_W-1:0] payload_out;
	logic [OCC_W-1:0]      occupancy;
	logic [CNT_W-1:0]      insert_total;
	logic [CNT_W-1:0]      delete_total;
	logic [CNT_W-1:0]      retrieve_total;

	modport source (output valid, output status, output payload_out, output occupancy,
		output insert_total, output delete_total, output retrieve_total, input ready);
	modport sink   (input valid, input status, input payload_out, input occupancy,
		input insert_total, input delete_total, input retrieve_total, output ready);
endinterface

>>> hdl/ukt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module ukt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/unique_key_table_with_compaction.sv
// Packed key/payload table with insert, delete-with-compaction and retrieve.
// A request scans the stored keys in order until a hit, or up to the occupancy on a miss; a
// delete then moves every later entry down one slot. Scan and shift together cross the table
// once. One request is in flight at a time: the sequencer takes a request only while idle,
// and the next transfer is taken the cycle after the result loads.
// Reset clears control, occupancy and counters; the memories are not cleared.
module unique_key_table_with_compaction import ukt_pkg::*; (
	input logic clk,
	input logic arst_n,
	ukt_req_if.sink   req,
	ukt_rsp_if.source rsp
);

	// Sequencer state and request held for the whole operation
	ukt_state_t              state_q, state_d;
	ukt_func_t               func_q;
	logic [KEY_W-1:0]        key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// Scan pointer: next address to read. pend_s1/idx_s1 tag the read data now arriving.
	logic [OCC_W-1:0]  scan_q, scan_d;
	logic              pend_s1, pend_d;
	logic [ADDR_W-1:0] idx_s1, idx_d;

	// Architectural state
	logic [OCC_W-1:0] fill_q, fill_d;
	logic [CNT_W-1:0] ins_q, ins_d;
	logic [CNT_W-1:0] del_q, del_d;
	logic [CNT_W-1:0] ret_q, ret_d;

	// Result of the current operation
	ukt_status_t             status_q, status_d;
	logic [PAYLOAD_BITS-1:0] pout_q, pout_d;

	// Output register
	logic                    rsp_vld_q;
	ukt_status_t             rsp_status_q;
	logic [PAYLOAD_BITS-1:0] rsp_pay_q;
	logic [OCC_W-1:0]        rsp_occ_q;
	logic [CNT_W-1:0]        rsp_ins_q;
	logic [CNT_W-1:0]        rsp_del_q;
	logic [CNT_W-1:0]        rsp_ret_q;

	// Memory ports
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_waddr;
	logic [KEY_W-1:0]        mem_wkey;
	logic [PAYLOAD_BITS-1:0] mem_wpay;
	logic [KEY_W-1:0]        key_rd;
	logic [PAYLOAD_BITS-1:0] pay_rd;

	logic accept;
	logic load_rsp;
	logic issue;
	logic hit;

	ukt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wkey),
		.raddr (scan_q[ADDR_W-1:0]),
		.rdata (key_rd)
	);

	ukt_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(CAPACITY)) u_pay_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wpay),
		.raddr (scan_q[ADDR_W-1:0]),
		.rdata (pay_rd)
	);

	assign accept = req.valid && req.ready;
	// A read is issued while the pointer is still inside the occupied region
	assign issue  = (scan_q < fill_q);
	// The shared comparator checks the key that arrives from the previous read
	assign hit    = pend_s1 && (key_rd == key_q);

	always_comb begin
		state_d   = state_q;
		scan_d    = scan_q;
		pend_d    = 1'b0;
		idx_d     = idx_s1;
		fill_d    = fill_q;
		ins_d     = ins_q;
		del_d     = del_q;
		ret_d     = ret_q;
		status_d  = status_q;
		pout_d    = pout_q;
		mem_we    = 1'b0;
		mem_waddr = fill_q[ADDR_W-1:0];
		mem_wkey  = key_q;
		mem_wpay  = pay_q;
		req.ready = 1'b0;
		load_rsp  = 1'b0;

		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					scan_d  = '0;
					pout_d  = '0;
					state_d = S_SCAN;
				end
			end

			S_SCAN: begin
				if (hit) begin
					case (func_q)
						FN_INSERT: begin
							status_d = ST_DUPLICATE;
							state_d  = S_DONE;
						end
						FN_DELETE: begin
							// Compact: move every later entry down one slot
							scan_d  = OCC_W'(idx_s1) + OCC_W'(1);
							state_d = S_SHIFT;
						end
						FN_RETRIEVE: begin
							status_d = ST_FOUND;
							pout_d   = pay_rd;
							ret_d    = sat_inc(ret_q);
							state_d  = S_DONE;
						end
						default: begin
							status_d = ST_NOT_FOUND;
							state_d  = S_DONE;
						end
					endcase
				end else if (!pend_s1 && !issue) begin
					// Every occupied slot compared with no match
					state_d  = S_DONE;
					status_d = ST_NOT_FOUND;
					if (func_q == FN_INSERT) begin
						if (fill_q == OCC_W'(CAPACITY)) begin
							status_d = ST_FULL;
						end else begin
							mem_we   = 1'b1;
							fill_d   = fill_q + OCC_W'(1);
							ins_d    = sat_inc(ins_q);
							status_d = ST_INSERTED;
						end
					end
				end else begin
					pend_d = issue;
					idx_d  = scan_q[ADDR_W-1:0];
					if (issue) begin
						scan_d = scan_q + OCC_W'(1);
					end
				end
			end

			S_SHIFT: begin
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 - ADDR_W'(1);
					mem_wkey  = key_rd;
					mem_wpay  = pay_rd;
				end
				if (!pend_s1 && !issue) begin
					fill_d   = fill_q - OCC_W'(1);
					del_d    = sat_inc(del_q);
					status_d = ST_DELETED;
					state_d  = S_DONE;
				end else begin
					pend_d = issue;
					idx_d  = scan_q[ADDR_W-1:0];
					if (issue) begin
						scan_d = scan_q + OCC_W'(1);
					end
				end
			end

			S_DONE: begin
				// Hold until the output register is free
				if (!rsp_vld_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			pend_s1 <= 1'b0;
			fill_q  <= '0;
			ins_q   <= '0;
			del_q   <= '0;
			ret_q   <= '0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			pend_s1 <= pend_d;
			fill_q  <= fill_d;
			ins_q   <= ins_d;
			del_q   <= del_d;
			ret_q   <= ret_d;
		end
	end

	// Request capture and per-operation result; payload only, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= ukt_func_t'(req.func);
			key_q  <= req.key;
			pay_q  <= req.payload[PAYLOAD_BITS-1:0];
		end
		idx_s1   <= idx_d;
		status_q <= status_d;
		pout_q   <= pout_d;
	end

	// Output register: valid drops on the transfer, reloads from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_status_q <= status_q;
			rsp_pay_q    <= pout_q;
			rsp_occ_q    <= fill_q;
			rsp_ins_q    <= ins_q;
			rsp_del_q    <= del_q;
			rsp_ret_q    <= ret_q;
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.payload_out    = PAY_PORT_W'(rsp_pay_q);
	assign rsp.occupancy      = rsp_occ_q;
	assign rsp.insert_total   = rsp_ins_q;
	assign rsp.delete_total   = rsp_del_q;
	assign rsp.retrieve_total = rsp_ret_q;

endmodule

>>> hdl/ukt_chk.sv
// Port-level checker for the unique key table and its bind statement.
module ukt_chk import ukt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [STATUS_W-1:0]   rsp_status,
	input logic [PAY_PORT_W-1:0] rsp_payload_out,
	input logic [OCC_W-1:0]      rsp_occupancy,
	input logic [CNT_W-1:0]      rsp_insert_total
);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_occupancy))
		else $error("result changed while stalled");

	// One request in flight: no transfer on the cycle after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_occupancy <= OCC_W'(CAPACITY))
		else $error("occupancy beyond capacity");

	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_FOUND |-> rsp_payload_out == '0)
		else $error("payload reported without a hit");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_INSERTED |-> rsp_insert_total != '0 && rsp_occupancy != '0)
		else $error("insert reported without count");

endmodule

bind unique_key_table_with_compaction ukt_chk u_ukt_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_payload_out  (rsp.payload_out),
	.rsp_occupancy    (rsp.occupancy),
	.rsp_insert_total (rsp.insert_total)
);
